// ===== rtl/htpr_pkg.sv =====
// ----------------------------------------------------------------------------
// htpr_pkg: shared types for the hashed table probe/replace block
// Command codes, configuration register indexes, slot layout, controller
// states and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package htpr_pkg;

	typedef enum logic [1:0] {
		CMD_PROBE   = 2'd0,
		CMD_WRITE   = 2'd1,
		CMD_ADVANCE = 2'd2,
		CMD_FILL    = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		CFG_USED_ENTRIES = 2'd0,
		CFG_MATED_BOUND  = 2'd1,
		CFG_MATE_BOUND   = 2'd2,
		CFG_EXACT_CODE   = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic [63:0] key;
		logic [7:0]  depth;
		logic [15:0] score;
		logic [15:0] eval;
		logic [15:0] move;
		logic [4:0]  gen;
		logic        pv;
		logic [1:0]  ntype;
	} slot_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_INDEX,
		ST_READ,
		ST_EVAL,
		ST_FILL,
		ST_DRAIN,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic capture;
		logic clear_step;
		logic calc_index;
		logic read_slot;
		logic finish;
		logic fill_step;
		logic load_out;
	} dp_ctl_t;

	typedef struct packed {
		logic clear_last;
		logic fill_last;
		logic out_free;
	} dp_sts_t;

endpackage

// ===== rtl/htpr_ctrl.sv =====
// ----------------------------------------------------------------------------
// htpr_ctrl: sequencer for the hashed table
// Runs the clearing sweep after reset, then steps each accepted word through
// index, read and evaluate, or the fill sweep, or straight to done for an advance,
// and hands the result to the output.
module htpr_ctrl (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [1:0]              cmd,
	input  htpr_pkg::dp_sts_t       sts,
	output htpr_pkg::dp_ctl_t       ctl
);

	htpr_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= htpr_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		ctl      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			htpr_pkg::ST_CLEAR: begin
				ctl.clear_step = 1'b1;
				if (sts.clear_last) begin
					state_d = htpr_pkg::ST_IDLE;
				end
			end
			htpr_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ctl.capture = 1'b1;
					unique case (cmd)
						htpr_pkg::CMD_PROBE,
						htpr_pkg::CMD_WRITE:   state_d = htpr_pkg::ST_INDEX;
						htpr_pkg::CMD_ADVANCE: state_d = htpr_pkg::ST_DONE;
						default:               state_d = htpr_pkg::ST_FILL;
					endcase
				end
			end
			htpr_pkg::ST_INDEX: begin
				ctl.calc_index = 1'b1;
				state_d = htpr_pkg::ST_READ;
			end
			htpr_pkg::ST_READ: begin
				ctl.read_slot = 1'b1;
				state_d = htpr_pkg::ST_EVAL;
			end
			htpr_pkg::ST_EVAL: begin
				ctl.finish = 1'b1;
				state_d = htpr_pkg::ST_DONE;
			end
			htpr_pkg::ST_FILL: begin
				ctl.fill_step = 1'b1;
				if (sts.fill_last) begin
					state_d = htpr_pkg::ST_DRAIN;
				end
			end
			htpr_pkg::ST_DRAIN: begin
				// The last slot read is counted at the end of this cycle.
				state_d = htpr_pkg::ST_DONE;
			end
			htpr_pkg::ST_DONE: begin
				if (sts.out_free) begin
					ctl.load_out = 1'b1;
					state_d = htpr_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = htpr_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// ===== rtl/htpr_dp.sv =====
// ----------------------------------------------------------------------------
// htpr_dp: datapath of the hashed table
// Slot memory, index multiplier, score adjustment, replacement rule,
// generation and fill counters, configuration and output registers.
// ----------------------------------------------------------------------------
module htpr_dp #(
	parameter int unsigned ENTRIES     = 4096,
	parameter int unsigned FILL_SAMPLE = 1000
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  htpr_pkg::dp_ctl_t    ctl,
	output htpr_pkg::dp_sts_t    sts,
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_index,
	input  logic [15:0]          cfg_data,
	input  logic [1:0]           cmd,
	input  logic [63:0]          key,
	input  logic [7:0]           ply,
	input  logic [15:0]          new_move,
	input  logic [7:0]           new_depth,
	input  logic signed [15:0]   new_eval,
	input  logic signed [15:0]   new_score,
	input  logic [1:0]           new_type,
	input  logic                 new_pv,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 hit,
	output logic [7:0]           found_depth,
	output logic [1:0]           found_type,
	output logic [15:0]          found_move,
	output logic signed [15:0]   found_eval,
	output logic signed [15:0]   found_score,
	output logic [9:0]           fill_count
);

	localparam int unsigned AW  = $clog2(ENTRIES);
	localparam int unsigned LIM = (FILL_SAMPLE < ENTRIES) ? FILL_SAMPLE : ENTRIES;

	// Adds or subtracts ply and saturates to the 16-bit range.
	function automatic logic [15:0] adj_sat(input logic [15:0] sc, input logic [7:0] p,
			input logic sub);
		logic signed [17:0] v;
		begin
			v = sub ? ($signed({{2{sc[15]}}, sc}) - $signed({10'd0, p}))
			        : ($signed({{2{sc[15]}}, sc}) + $signed({10'd0, p}));
			if (v > 18'sd32767) begin
				adj_sat = 16'h7FFF;
			end else if (v < -18'sd32768) begin
				adj_sat = 16'h8000;
			end else begin
				adj_sat = v[15:0];
			end
		end
	endfunction

	htpr_pkg::slot_t mem [ENTRIES];

	logic [12:0]        used_q;
	logic signed [15:0] mated_q, mate_q;
	logic [1:0]         exact_q;
	logic [4:0]         gen_q;

	htpr_pkg::cmd_t     cmd_q;
	logic [63:0]        key_q;
	logic [7:0]         ply_q, ndepth_q;
	logic [15:0]        nmove_q, neval_q, nscore_q;
	logic [1:0]         ntype_q;
	logic               npv_q;

	logic [76:0]        prod_s1;
	logic [AW-1:0]      idx_q, ptr_q;
	htpr_pkg::slot_t    rdata_q;
	logic               fill_rd_s1;
	logic [10:0]        cnt_q;

	logic               res_hit_q;
	logic [15:0]        res_score_q;

	logic [12:0]        n_eff;
	logic [12:0]        top;
	logic               we;
	logic [AW-1:0]      waddr, raddr;
	htpr_pkg::slot_t    wdata, new_slot;
	logic [15:0]        wscore, pscore;
	logic               key_eq, replace;
	logic [9:0]         depth_lhs;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q  <= 13'd4096;
			mated_q <= -16'sd31000;
			mate_q  <= 16'sd31000;
			exact_q <= 2'd3;
		end else if (cfg_we) begin
			unique case (cfg_index)
				htpr_pkg::CFG_USED_ENTRIES: used_q  <= cfg_data[12:0];
				htpr_pkg::CFG_MATED_BOUND:  mated_q <= cfg_data;
				htpr_pkg::CFG_MATE_BOUND:   mate_q  <= cfg_data;
				default:                    exact_q <= cfg_data[1:0];
			endcase
		end
	end

	// Input word capture.
	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			cmd_q    <= htpr_pkg::cmd_t'(cmd);
			key_q    <= key;
			ply_q    <= ply;
			nmove_q  <= new_move;
			ndepth_q <= new_depth;
			neval_q  <= new_eval;
			nscore_q <= new_score;
			ntype_q  <= new_type;
			npv_q    <= new_pv;
		end
	end

	// Slot index is the high word of key times the slots in use.
	assign n_eff = (32'(used_q) > ENTRIES) ? 13'(ENTRIES) : used_q;
	assign top   = prod_s1[76:64];

	always_ff @(posedge clk) begin
		if (ctl.calc_index) begin
			prod_s1 <= 77'(key_q) * 77'(n_eff);
		end
		if (ctl.read_slot) begin
			idx_q <= AW'(top);
		end
	end

	// Sweep pointer serves both the clearing pass and the fill sweep.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q      <= '0;
			fill_rd_s1 <= 1'b0;
			cnt_q      <= '0;
		end else begin
			fill_rd_s1 <= ctl.fill_step;
			if (ctl.capture) begin
				ptr_q <= '0;
				cnt_q <= '0;
			end else if (ctl.clear_step || ctl.fill_step) begin
				ptr_q <= ptr_q + AW'(1);
			end
			if (fill_rd_s1 && (rdata_q.gen == gen_q)) begin
				cnt_q <= cnt_q + 11'd1;
			end
		end
	end

	assign sts.clear_last = (ptr_q == AW'(ENTRIES - 1));
	assign sts.fill_last  = (ptr_q == AW'(LIM - 1));
	assign sts.out_free   = !out_valid || out_ready;

	// Replacement rule and the word written back on a write command.
	assign key_eq    = (rdata_q.key == key_q);
	assign depth_lhs = {2'd0, ndepth_q} + 10'd4 + {8'd0, rdata_q.pv, 1'b0};
	assign replace   = (ntype_q == exact_q) || (rdata_q.gen != gen_q) || !key_eq
		|| (depth_lhs >= {2'd0, rdata_q.depth});

	always_comb begin
		if ($signed(nscore_q) < mated_q) begin
			wscore = adj_sat(nscore_q, ply_q, 1'b1);
		end else if ($signed(nscore_q) > mate_q) begin
			wscore = adj_sat(nscore_q, ply_q, 1'b0);
		end else begin
			wscore = nscore_q;
		end
		if ($signed(rdata_q.score) < mated_q) begin
			pscore = adj_sat(rdata_q.score, ply_q, 1'b0);
		end else if ($signed(rdata_q.score) > mate_q) begin
			pscore = adj_sat(rdata_q.score, ply_q, 1'b1);
		end else begin
			pscore = rdata_q.score;
		end
	end

	always_comb begin
		new_slot.key   = key_q;
		new_slot.depth = ndepth_q;
		new_slot.score = wscore;
		new_slot.eval  = neval_q;
		new_slot.move  = ((nmove_q != 16'd0) || !key_eq) ? nmove_q : rdata_q.move;
		new_slot.gen   = gen_q;
		new_slot.pv    = npv_q;
		new_slot.ntype = ntype_q;
	end

	assign we    = ctl.clear_step
		|| (ctl.finish && (cmd_q == htpr_pkg::CMD_WRITE) && replace);
	assign waddr = ctl.clear_step ? ptr_q : idx_q;
	assign wdata = ctl.clear_step ? '0 : new_slot;
	assign raddr = ctl.fill_step ? ptr_q : AW'(top);

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (ctl.read_slot || ctl.fill_step) begin
			rdata_q <= mem[raddr];
		end
	end

	// Probe result held until the output register takes it.
	always_ff @(posedge clk) begin
		if (ctl.finish) begin
			res_hit_q   <= key_eq;
			res_score_q <= key_eq ? pscore : 16'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gen_q     <= '0;
			out_valid <= 1'b0;
		end else begin
			if (ctl.load_out) begin
				out_valid <= 1'b1;
				if (cmd_q == htpr_pkg::CMD_ADVANCE) begin
					gen_q <= gen_q + 5'd1;
				end
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load_out) begin
			if (cmd_q == htpr_pkg::CMD_PROBE) begin
				hit         <= res_hit_q;
				found_depth <= rdata_q.depth;
				found_type  <= rdata_q.ntype;
				found_move  <= rdata_q.move;
				found_eval  <= rdata_q.eval;
				found_score <= res_score_q;
			end else begin
				hit         <= 1'b0;
				found_depth <= '0;
				found_type  <= '0;
				found_move  <= '0;
				found_eval  <= '0;
				found_score <= '0;
			end
			if (cmd_q == htpr_pkg::CMD_FILL) begin
				fill_count <= cnt_q[10] ? 10'h3FF : cnt_q[9:0];
			end else begin
				fill_count <= '0;
			end
		end
	end

endmodule

// ===== rtl/hashed_table_probe_replace.sv =====
// ----------------------------------------------------------------------------
// hashed_table_probe_replace: direct-mapped search result table
// Probe, replace-by-rule write, generation advance and fill count.
// ----------------------------------------------------------------------------
// Probe and write pass through index, read and evaluate; advance goes straight
// to the result. A fill count reads min(FILL_SAMPLE, ENTRIES) slots, one per
// cycle on the single memory read port. One word is in work at a time.
// After reset a clearing pass zeroes all ENTRIES slots, one per cycle, and
// no word is accepted until it ends; configuration writes are taken always.
module hashed_table_probe_replace #(
	parameter int unsigned ENTRIES     = 4096,
	parameter int unsigned FILL_SAMPLE = 1000
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_index,
	input  logic [15:0]          cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [1:0]           cmd,
	input  logic [63:0]          key,
	input  logic [7:0]           ply,
	input  logic [15:0]          new_move,
	input  logic [7:0]           new_depth,
	input  logic signed [15:0]   new_eval,
	input  logic signed [15:0]   new_score,
	input  logic [1:0]           new_type,
	input  logic                 new_pv,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 hit,
	output logic [7:0]           found_depth,
	output logic [1:0]           found_type,
	output logic [15:0]          found_move,
	output logic signed [15:0]   found_eval,
	output logic signed [15:0]   found_score,
	output logic [9:0]           fill_count
);

	htpr_pkg::dp_ctl_t ctl;
	htpr_pkg::dp_sts_t sts;

	htpr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.cmd      (cmd),
		.sts      (sts),
		.ctl      (ctl)
	);

	htpr_dp #(
		.ENTRIES     (ENTRIES),
		.FILL_SAMPLE (FILL_SAMPLE)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.sts         (sts),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.cmd         (cmd),
		.key         (key),
		.ply         (ply),
		.new_move    (new_move),
		.new_depth   (new_depth),
		.new_eval    (new_eval),
		.new_score   (new_score),
		.new_type    (new_type),
		.new_pv      (new_pv),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.hit         (hit),
		.found_depth (found_depth),
		.found_type  (found_type),
		.found_move  (found_move),
		.found_eval  (found_eval),
		.found_score (found_score),
		.fill_count  (fill_count)
	);

endmodule
